FILE: hdl/tnc_pkg.sv
// Shared types, constants and register codes for the timer tick/nanosecond converter.
package tnc_pkg;

    // Field and datapath widths.
    localparam int OPND_W  = 64;
    localparam int FREQ_W  = 32;
    localparam int PROD_W  = OPND_W + FREQ_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // The divider retires this many quotient bits in each stage.
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = PROD_W / DIV_STEP;

    // Operand preparation plus the split multiply.
    localparam int MUL_STAGES = 4;

    // Cycles from an accepted transaction to its result strobe.
    localparam int PIPE_LATENCY = MUL_STAGES + DIV_STAGES + 1;

    localparam logic [FREQ_W-1:0] NS_PER_SEC = 32'd1_000_000_000;

    // Command codes.
    localparam logic CMD_TO_NS    = 1'b0;
    localparam logic CMD_TO_COUNT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;

    typedef struct packed {
        logic valid;
        logic cmd;
        logic err;
    } t_ctl;

    // State carried between divider stages: partial remainder plus a word that
    // shifts dividend bits out at the top and quotient bits in at the bottom.
    typedef struct packed {
        t_ctl              ctl;
        logic [FREQ_W-1:0] rem;
        logic [PROD_W-1:0] work;
    } t_div;

endpackage

FILE: hdl/timer_tick_ns_converter.sv
// Top level of the timer tick/nanosecond converter: configuration, pipeline and result.
//
// This block converts between a free-running counter and nanoseconds. A transaction
// with i_cmd at 0 takes a raw counter sample, subtracts the start count (wrapping
// modulo 2^64) and returns floor(delta * 1e9 / counter_frequency). A transaction with
// i_cmd at 1 takes a nanosecond deadline and returns floor(ns * counter_frequency /
// 1e9) plus the start count, which is the compare value for the counter. Both use a
// full 96-bit product and return the quotient modulo 2^64. A tick-to-ns transaction
// met with a zero frequency returns 0 with o_divide_error set. The block is a fully
// pipelined datapath: a transaction is accepted at any edge where start is high and
// busy is low, one per clock, and busy is high only during reset and in the cycle
// that follows it. Each result appears on o_converted_value and o_divide_error for
// exactly one cycle, marked by o_valid, in the order the transactions were accepted.
// Operand preparation and split 32-bit multiplies are followed by twenty-four divider
// stages that each retire four quotient bits, and then by the output register. The
// receiver cannot stall the block, so nothing ever backs up.
// The two configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data (index 0 is the frequency in hertz, index 1 the start count; other
// indexes are ignored) and must only be changed while no transaction is in flight.
module timer_tick_ns_converter
    import tnc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cmd,
    input  logic [OPND_W-1:0]     i_operand_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [OPND_W-1:0]     o_converted_value,
    output logic                  o_divide_error
);

    // Configuration registers.
    logic [FREQ_W-1:0] r_freq;
    logic [OPND_W-1:0] r_start_count;
    // Busy is held only across reset so that nothing enters a pipeline being cleared.
    logic              r_busy;

    logic              w_accept;
    t_ctl              w_mul_ctl;
    logic [PROD_W-1:0] w_mul_prod;
    t_div              w_div [0:DIV_STAGES];

    // Output register.
    logic              r_valid, n_valid;
    logic [OPND_W-1:0] r_value, n_value;
    logic              r_err, n_err;
    logic [OPND_W-1:0] w_quot;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_freq        <= '0;
            r_start_count <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FREQ:  r_freq        <= i_cfg_data[FREQ_W-1:0];
                    REG_START: r_start_count <= i_cfg_data[OPND_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // Operand preparation and the 96-bit product.
    tnc_mul u_mul (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_accept),
        .i_cmd           (i_cmd),
        .i_operand_value (i_operand_value),
        .i_freq          (r_freq),
        .i_start_count   (r_start_count),
        .o_ctl           (w_mul_ctl),
        .o_prod          (w_mul_prod)
    );

    // The divider starts with a zero remainder and the whole product to shift in.
    assign w_div[0].ctl  = w_mul_ctl;
    assign w_div[0].rem  = '0;
    assign w_div[0].work = w_mul_prod;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        tnc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_freq  (r_freq),
            .i_bus   (w_div[g]),
            .o_bus   (w_div[g+1])
        );
    end

    // The quotient has 96 bits; only the low 64 are kept, which wraps the result.
    assign w_quot = w_div[DIV_STAGES].work[OPND_W-1:0];

    always_comb begin
        n_valid = w_div[DIV_STAGES].ctl.valid;
        n_err   = w_div[DIV_STAGES].ctl.err;
        if (w_div[DIV_STAGES].ctl.err) begin
            n_value = '0;
        end else if (w_div[DIV_STAGES].ctl.cmd == CMD_TO_COUNT) begin
            n_value = w_quot + r_start_count;
        end else begin
            n_value = w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_err   <= n_err;
    end

    assign o_valid           = r_valid;
    assign o_converted_value = r_value;
    assign o_divide_error    = r_err;

    // Every result strobe traces back to a transaction accepted a fixed latency earlier.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without a matching accepted transaction");

    // A divide error only comes from a tick-to-ns transaction.
    a_err_only_to_ns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> ($past(i_cmd, PIPE_LATENCY) == CMD_TO_NS))
        else $error("divide error flagged on a deadline conversion");

    // A divide error forces a zero value.
    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_converted_value == '0))
        else $error("divide error with a nonzero converted value");

endmodule

FILE: hdl/tnc_mul.sv
// Operand preparation and the pipelined 64 x 32 bit multiply of the converter.
module tnc_mul
    import tnc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cmd,
    input  logic [OPND_W-1:0] i_operand_value,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [OPND_W-1:0] i_start_count,
    output t_ctl              o_ctl,
    output logic [PROD_W-1:0] o_prod
);

    // Stage 1: elapsed ticks or deadline, and the multiplier constant.
    t_ctl              r_s1_ctl, n_s1_ctl;
    logic [OPND_W-1:0] r_s1_a, n_s1_a;
    logic [FREQ_W-1:0] r_s1_b, n_s1_b;
    // Stage 2: low partial product.
    t_ctl              r_s2_ctl;
    logic [FREQ_W-1:0] r_s2_a_hi;
    logic [FREQ_W-1:0] r_s2_b;
    logic [OPND_W-1:0] r_s2_plo;
    // Stage 3: high partial product.
    t_ctl              r_s3_ctl;
    logic [OPND_W-1:0] r_s3_plo;
    logic [OPND_W-1:0] r_s3_phi;
    // Stage 4: the full 96-bit product.
    t_ctl              r_s4_ctl;
    logic [PROD_W-1:0] r_s4_prod;

    logic [OPND_W-1:0] w_plo;
    logic [OPND_W-1:0] w_phi;
    logic [OPND_W-1:0] w_phi_sum;

    always_comb begin
        n_s1_ctl.valid = i_valid;
        n_s1_ctl.cmd   = i_cmd;
        n_s1_ctl.err   = (i_cmd == CMD_TO_NS) && (i_freq == '0);
        if (i_cmd == CMD_TO_NS) begin
            n_s1_a = i_operand_value - i_start_count;
            n_s1_b = NS_PER_SEC;
        end else begin
            n_s1_a = i_operand_value;
            n_s1_b = i_freq;
        end
    end

    assign w_plo     = r_s1_a[FREQ_W-1:0] * r_s1_b;
    assign w_phi     = r_s2_a_hi * r_s2_b;
    assign w_phi_sum = r_s3_phi + {{(OPND_W-FREQ_W){1'b0}}, r_s3_plo[OPND_W-1:FREQ_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a    <= n_s1_a;
        r_s1_b    <= n_s1_b;
        r_s2_a_hi <= r_s1_a[OPND_W-1:FREQ_W];
        r_s2_b    <= r_s1_b;
        r_s2_plo  <= w_plo;
        r_s3_plo  <= r_s2_plo;
        r_s3_phi  <= w_phi;
        r_s4_prod <= {w_phi_sum, r_s3_plo[FREQ_W-1:0]};
    end

    assign o_ctl  = r_s4_ctl;
    assign o_prod = r_s4_prod;

endmodule

FILE: hdl/tnc_div_stage.sv
// One stage of the restoring divider, retiring DIV_STEP quotient bits per cycle.
module tnc_div_stage
    import tnc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [FREQ_W-1:0] i_freq,
    input  t_div              i_bus,
    output t_div              o_bus
);

    t_ctl              r_ctl;
    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_work, n_work;
    logic [FREQ_W-1:0] w_divisor;
    logic [FREQ_W:0]   w_part;

    // The divisor is the frequency for tick-to-ns and one second otherwise.
    assign w_divisor = (i_bus.ctl.cmd == CMD_TO_NS) ? i_freq : NS_PER_SEC;

    always_comb begin
        n_rem  = i_bus.rem;
        n_work = i_bus.work;
        w_part = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            w_part = {n_rem, n_work[PROD_W-1]};
            n_work = {n_work[PROD_W-2:0], 1'b0};
            if (w_part >= {1'b0, w_divisor}) begin
                w_part    = w_part - {1'b0, w_divisor};
                n_work[0] = 1'b1;
            end
            n_rem = w_part[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_bus.ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_work <= n_work;
    end

    assign o_bus.ctl  = r_ctl;
    assign o_bus.rem  = r_rem;
    assign o_bus.work = r_work;

endmodule
